FILE: rtl/tea_block_cipher_macros.svh
// Assertion macros used by the checker file
`ifndef TEA_BLOCK_CIPHER_MACROS_SVH
`define TEA_BLOCK_CIPHER_MACROS_SVH

// assertion that is switched off while reset is high
`define TEA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that also holds across reset
`define TEA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tea_pkg.sv
// Types and constants for the TEA block cipher
package tea_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } tea_cmd_t;

  typedef enum logic [1:0] {
    KEY_IDX_0 = 2'd0,
    KEY_IDX_1 = 2'd1,
    KEY_IDX_2 = 2'd2,
    KEY_IDX_3 = 2'd3
  } tea_key_idx_t;

  typedef logic [3:0][31:0] tea_key_t;

  typedef struct packed {
    tea_cmd_t    cmd;
    logic [31:0] w0;
    logic [31:0] w1;
  } tea_data_t;

endpackage

FILE: rtl/tea_stage.sv
// One half-round pipeline stage of the TEA cipher
module tea_stage #(
  parameter bit          SECOND  = 1'b0,
  parameter logic [31:0] SUM_ENC = 32'h0000_0000,
  parameter logic [31:0] SUM_DEC = 32'h0000_0000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  tea_pkg::tea_key_t  key,
  input  logic               valid_in,
  input  tea_pkg::tea_data_t data_in,
  output logic               valid_out,
  output tea_pkg::tea_data_t data_out
);
  import tea_pkg::*;

  function automatic logic [31:0] half_mix(input logic [31:0] v, input logic [31:0] sum,
                                           input logic [31:0] ka, input logic [31:0] kb);
    half_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

  logic      is_dec;
  logic [31:0] mix_src;
  logic [31:0] mix_sum;
  logic [31:0] mix_ka;
  logic [31:0] mix_kb;
  logic [31:0] mix;
  tea_data_t data_next;

  assign is_dec  = (data_in.cmd == CMD_DECRYPT);
  assign mix_sum = is_dec ? SUM_DEC : SUM_ENC;

  // encrypt: v0 += f(v1, k0, k1) then v1 += f(v0, k2, k3)
  // decrypt: v1 -= f(v0, k2, k3) then v0 -= f(v1, k0, k1)
  always_comb begin
    if (is_dec ^ SECOND) begin
      mix_src = data_in.w0;
      mix_ka  = key[2];
      mix_kb  = key[3];
    end else begin
      mix_src = data_in.w1;
      mix_ka  = key[0];
      mix_kb  = key[1];
    end
  end

  assign mix = half_mix(mix_src, mix_sum, mix_ka, mix_kb);

  always_comb begin
    data_next = data_in;
    if (is_dec ^ SECOND) begin
      data_next.w1 = is_dec ? (data_in.w1 - mix) : (data_in.w1 + mix);
    end else begin
      data_next.w0 = is_dec ? (data_in.w0 - mix) : (data_in.w0 + mix);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_out <= data_next;
    end
  end

endmodule

FILE: rtl/tea_block_cipher.sv
// Top level of the pipelined TEA block cipher
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    command, block_word_0, block_word_1
//   out      output     out_valid / out_ready  out_word_0, out_word_1
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// One block per cycle while the pipe advances; one stage per half-round.
// The last stage is the output register; the whole pipe holds when it is full
// and not taken, so in_ready follows out_ready through one gate.
// Reset clears the stage valid bits and the four key words.
module tea_block_cipher #(
  parameter int ROUND_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] block_word_0,
  input  logic [31:0] block_word_1,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word_0,
  output logic [31:0] out_word_1,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tea_pkg::*;

  localparam int NumStages = 2 * ROUND_COUNT;

  tea_key_t  key;
  logic      advance;
  logic      stage_valid [0:NumStages];
  tea_data_t stage_data  [0:NumStages];

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      unique case (tea_key_idx_t'(cfg_index))
        KEY_IDX_0: key[0] <= cfg_data;
        KEY_IDX_1: key[1] <= cfg_data;
        KEY_IDX_2: key[2] <= cfg_data;
        KEY_IDX_3: key[3] <= cfg_data;
        default:   key    <= key;
      endcase
    end
  end

  assign advance  = !stage_valid[NumStages] || out_ready;
  assign in_ready = advance;

  assign stage_valid[0] = in_valid;
  assign stage_data[0]  = '{cmd: tea_cmd_t'(command), w0: block_word_0, w1: block_word_1};

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    localparam int          Round  = s / 2;
    localparam logic [31:0] SumEnc = 32'(64'(TEA_DELTA) * 64'(Round + 1));
    localparam logic [31:0] SumDec = 32'(64'(TEA_DELTA) * 64'(ROUND_COUNT - Round));

    tea_stage #(
      .SECOND  (1'((s % 2) == 1)),
      .SUM_ENC (SumEnc),
      .SUM_DEC (SumDec)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .key       (key),
      .valid_in  (stage_valid[s]),
      .data_in   (stage_data[s]),
      .valid_out (stage_valid[s + 1]),
      .data_out  (stage_data[s + 1])
    );
  end

  assign out_valid  = stage_valid[NumStages];
  assign out_word_0 = stage_data[NumStages].w0;
  assign out_word_1 = stage_data[NumStages].w1;

endmodule

FILE: rtl/tea_checker.sv
// Port-level checks for the TEA block cipher, bound to the top level
`include "tea_block_cipher_macros.svh"

module tea_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word_0,
  input logic [31:0] out_word_1
);

  logic        out_stall;
  logic [63:0] out_pair;

  assign out_stall = out_valid && !out_ready;
  assign out_pair  = {out_word_0, out_word_1};

  `TEA_ASSERT(a_out_hold, out_stall |=> out_valid, "result dropped while stalled")
  `TEA_ASSERT(a_out_stable, out_stall |=> $stable(out_pair), "result changed while stalled")
  `TEA_ASSERT(a_ready_follows, in_ready == (!out_valid || out_ready), "input ready wrong")
  `TEA_ASSERT_RST(a_reset_empty, $past(rst) |-> !out_valid, "result shown after reset")

endmodule

bind tea_block_cipher tea_checker u_tea_checker (.*);

FILE: tb/tb_tea_block_cipher.sv
// Self-checking testbench for the pipelined TEA block cipher: directed table, keyed random phases
module tb_tea_block_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  import tea_pkg::*;

  localparam int ROUNDS           = 32;
  localparam int PIPE_DEPTH       = 2 * ROUNDS;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int PHASES           = 8;
  localparam int BLOCKS_PER_PHASE = 200;
  localparam int HOLD_CYCLES      = 300;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
  } word_pair_t;

  typedef struct {
    tea_cmd_t    cmd;
    logic [31:0] w0;
    logic [31:0] w1;
    bit          typed;
    word_pair_t  want;
  } vector_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [31:0] block_word_0;
  logic [31:0] block_word_1;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_word_0;
  logic [31:0] out_word_1;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  logic [31:0] key_copy [4];
  word_pair_t  pending_blocks [$];
  int          errors;
  int          cycles;
  int          n_checked;
  int          n_encrypt;
  int          n_decrypt;
  int          n_keys;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;

  tea_block_cipher #(.ROUND_COUNT(ROUNDS)) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .block_word_0(block_word_0),
    .block_word_1(block_word_1),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word_0  (out_word_0),
    .out_word_1  (out_word_1),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one half-round mixing term
  function automatic logic [31:0] round_mix(input logic [31:0] v, input logic [31:0] sum,
                                            input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = (v << 4) + ka;
    lo = (v >> 5) + kb;
    return hi ^ (v + sum) ^ lo;
  endfunction

  function automatic word_pair_t tea_transform(input tea_cmd_t cmd, input logic [31:0] a,
                                               input logic [31:0] b);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
    v0 = a;
    v1 = b;
    if (cmd == CMD_ENCRYPT) begin
      sum = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        sum = sum + TEA_DELTA;
        v0  = v0 + round_mix(v1, sum, key_copy[0], key_copy[1]);
        v1  = v1 + round_mix(v0, sum, key_copy[2], key_copy[3]);
      end
    end else begin
      sum = TEA_DELTA * 32'(ROUNDS);
      for (int r = 0; r < ROUNDS; r++) begin
        v1  = v1 - round_mix(v0, sum, key_copy[2], key_copy[3]);
        v0  = v0 - round_mix(v1, sum, key_copy[0], key_copy[1]);
        sum = sum - TEA_DELTA;
      end
    end
    return '{w0: v0, w1: v1};
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(31);
      3: return ~(32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic write_key(input tea_key_idx_t idx, input logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    key_copy[idx] = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    write_key(KEY_IDX_0, k0);
    write_key(KEY_IDX_1, k1);
    write_key(KEY_IDX_2, k2);
    write_key(KEY_IDX_3, k3);
    n_keys++;
  endtask

  task automatic push_block(input tea_cmd_t cmd, input logic [31:0] a, input logic [31:0] b,
                            input bit typed, input word_pair_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    command      = cmd;
    block_word_0 = a;
    block_word_1 = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_blocks.push_back(typed ? want : tea_transform(cmd, a, b));
    if (cmd == CMD_ENCRYPT) n_encrypt++;
    else n_decrypt++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // output side: random back-pressure plus a long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_output
    word_pair_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_blocks.size() == 0) begin
        $display("%0t: unexpected transfer, got %08h %08h", $time, out_word_0, out_word_1);
        errors++;
      end else begin
        want = pending_blocks.pop_front();
        n_checked++;
        if (out_word_0 !== want.w0) begin
          $display("%0t: out_word_0 expected %08h, got %08h", $time, want.w0, out_word_0);
          errors++;
        end
        if (out_word_1 !== want.w1) begin
          $display("%0t: out_word_1 expected %08h, got %08h", $time, want.w1, out_word_1);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d blocks outstanding", $time, pending_blocks.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    vector_row_t  vectors [$];
    tea_cmd_t     cmd;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  plain0;
    logic [31:0]  plain1;
    word_pair_t   cipher;
    bit           have_cipher;
    word_pair_t   none;

    rst           = 1'b1;
    in_valid      = 1'b0;
    command       = CMD_ENCRYPT;
    block_word_0  = '0;
    block_word_1  = '0;
    cfg_we        = 1'b0;
    cfg_index     = KEY_IDX_0;
    cfg_data      = '0;
    errors        = 0;
    cycles        = 0;
    n_checked     = 0;
    n_encrypt     = 0;
    n_decrypt     = 0;
    n_keys        = 1;
    send_idle_pct = 17;
    recv_idle_pct = 61;
    hold_req      = 1'b0;
    none          = '0;
    plain0        = '0;
    plain1        = '0;
    have_cipher   = 1'b0;
    foreach (key_copy[i]) key_copy[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // key is all zero after reset
    vectors = '{
      '{CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h41EA_3A0A, 32'h94BA_A940}},
      '{CMD_DECRYPT, 32'h41EA_3A0A, 32'h94BA_A940, 1'b1, '{32'h0000_0000, 32'h0000_0000}},
      '{CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0, none},
      '{CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none},
      '{CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none},
      '{CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, none},
      '{CMD_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, none},
      '{CMD_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, none},
      '{CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, none},
      '{CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0, none},
      '{CMD_ENCRYPT, 32'h0000_0001, 32'h8000_0000, 1'b0, none},
      '{CMD_DECRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0, none},
      '{CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, none},
      '{CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, none},
      '{CMD_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF, 1'b0, none},
      '{CMD_DECRYPT, 32'h89AB_CDEF, 32'h0123_4567, 1'b0, none},
      '{CMD_ENCRYPT, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 1'b0, none},
      '{CMD_DECRYPT, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 1'b0, none}
    };
    foreach (vectors[i])
      push_block(vectors[i].cmd, vectors[i].w0, vectors[i].w1, vectors[i].typed,
                 vectors[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: load_key(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        2: load_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        default: load_key($urandom, $urandom, $urandom, $urandom);
      endcase
      if (p < 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 61;
      end else if (p < 6) begin
        send_idle_pct = 61;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 2 || p == 7) hold_req = 1'b1;
      have_cipher = 1'b0;
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        // some decrypts of an earlier ciphertext, which must give the plaintext back
        if (have_cipher && $urandom_range(99) < 20) begin
          push_block(CMD_DECRYPT, cipher.w0, cipher.w1, 1'b1, '{plain0, plain1});
          have_cipher = 1'b0;
        end else begin
          cmd = tea_cmd_t'($urandom_range(1));
          a   = pick_word();
          b   = pick_word();
          push_block(cmd, a, b, 1'b0, none);
          if (cmd == CMD_ENCRYPT) begin
            cipher      = tea_transform(cmd, a, b);
            plain0      = a;
            plain1      = b;
            have_cipher = 1'b1;
          end
        end
      end
    end

    drain();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    $display("Checked %0d blocks (%0d encrypt, %0d decrypt) under %0d key settings,",
             n_checked, n_encrypt, n_decrypt, n_keys);
    $display("with random stalls on both sides and a %0d-cycle output hold.", HOLD_CYCLES);
    if (errors == 0 && pending_blocks.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tea_pkg.sv
rtl/tea_stage.sv
rtl/tea_block_cipher.sv
rtl/tea_checker.sv
tb/tb_tea_block_cipher.sv
